// File: hdl/hldf_pkg.sv
// shared types and constants for the header/length frame deframer
// used by every module under hdl; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hldf_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 17;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned TDATA_W  = 56;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h4D;  // 'M'
  localparam logic [BYTE_W-1:0] HDR_THIRD  = 8'h54;  // 'T'
  localparam logic [BYTE_W-1:0] DIGIT_BASE = 8'h30;  // '0'

  localparam logic [POS_W-1:0] POS_WINDOW_FULL = 17'd2;
  localparam logic [POS_W-1:0] POS_COMMAND     = 17'd3;
  localparam logic [POS_W-1:0] POS_LEN_HIGH    = 17'd4;
  localparam logic [POS_W-1:0] POS_LEN_LOW     = 17'd5;

  localparam logic [PADDR_W-1:0] ADDR_SLOT_ID = 3'd0;

  typedef struct packed {
    logic [LEN_W-1:0]  payload_length;
    logic [BYTE_W-1:0] command_code;
    logic [POS_W-1:0]  frame_position;
    logic [BYTE_W-1:0] data_byte;
    logic              last_of_frame;
  } hldf_result_t;

  typedef struct packed {
    logic out_valid;
    logic skid_valid;
  } hldf_buf_status_t;

endpackage

`default_nettype wire

// File: hdl/header_length_frame_deframer.sv
// top level: register port, header/length parser and output buffer
// depends on hldf_pkg, hldf_parser, hldf_out_buf
//
//   channel   direction  tdata / data                               side band
//   s_*       in         [7:0] rx_byte                              -
//   m_*       out        [7:0] data_byte, [24:8] frame_position,    tlast = last_of_frame
//                        [32:25] command_code, [48:33] payload_length
//   apb       in/out     0x0 slot_id [3:0]                          pready tied high
//
// one byte accepted per cycle while s_tready is high; a result is registered in the output
// register or skid entry. the three header bytes and all hunted bytes give no result.
// s_tready drops only when both the output register and the skid entry are full.
// synchronous reset clears the parser to hunting, slot_id to zero, both buffers empty.
`timescale 1ns / 1ps
`default_nettype none

module header_length_frame_deframer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [hldf_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // [7:0] data_byte, [24:8] frame_position, [32:25] command_code,
  // [48:33] payload_length, [55:49] zero
  output logic [hldf_pkg::TDATA_W-1:0]        m_tdata,
  output logic                                m_tlast,   // last_of_frame
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [hldf_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [hldf_pkg::PDATA_W-1:0]   pwdata,
  output logic [hldf_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  logic [hldf_pkg::SLOT_W-1:0] slot_id;
  logic                        s_accept;
  logic                        res_valid;
  hldf_pkg::hldf_result_t      res;
  hldf_pkg::hldf_result_t      out_res;
  hldf_pkg::hldf_buf_status_t  buf_status;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_id <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == hldf_pkg::ADDR_SLOT_ID)) begin
      slot_id <= pwdata[hldf_pkg::SLOT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == hldf_pkg::ADDR_SLOT_ID) begin
      prdata[hldf_pkg::SLOT_W-1:0] = slot_id;
    end
  end

  assign s_accept = s_tvalid && s_tready;

  hldf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_accept),
    .rx_byte   (s_tdata),
    .slot_id   (slot_id),
    .res_valid (res_valid),
    .res       (res)
  );

  hldf_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_res   (res),
    .can_accept (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (out_res),
    .status     (buf_status)
  );

  assign m_tdata = {7'd0, out_res.payload_length, out_res.command_code,
                    out_res.frame_position, out_res.data_byte};
  assign m_tlast = out_res.last_of_frame;

  // skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    buf_status.skid_valid |-> buf_status.out_valid)
    else $error("skid entry valid with empty output register");

  // the flagged byte sits at length plus five
  a_last_position: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |->
      (out_res.frame_position == ({1'b0, out_res.payload_length} + hldf_pkg::POS_LEN_LOW)))
    else $error("last byte at wrong frame position");

  // header bytes never leave the block
  a_no_header_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_res.frame_position >= hldf_pkg::POS_COMMAND))
    else $error("result with position inside header");

  // a blocked input only happens while both output slots hold results
  a_ready_low_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (buf_status.out_valid && buf_status.skid_valid))
    else $error("input stalled with free output space");

endmodule

`default_nettype wire

// File: hdl/hldf_parser.sv
// header hunt and frame field tracking, one byte per cycle while accept is high
// depends on hldf_pkg
`timescale 1ns / 1ps
`default_nettype none

module hldf_parser (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic [hldf_pkg::BYTE_W-1:0]   rx_byte,
  input  wire logic [hldf_pkg::SLOT_W-1:0]   slot_id,
  output logic                               res_valid,
  output hldf_pkg::hldf_result_t             res
);

  logic [hldf_pkg::BYTE_W-1:0] hunt_window [2];
  logic [hldf_pkg::BYTE_W-1:0] hunt_window_next [2];
  logic [hldf_pkg::POS_W-1:0]  byte_count, byte_count_next;
  logic [hldf_pkg::LEN_W-1:0]  length_value, length_value_next;
  logic [hldf_pkg::BYTE_W-1:0] length_high_byte, length_high_byte_next;
  logic [hldf_pkg::BYTE_W-1:0] command_hold, command_hold_next;
  logic                        header_locked, header_locked_next;

  logic [hldf_pkg::BYTE_W-1:0] hdr_second;
  logic                        hdr_match;
  logic                        past_length;
  logic                        last;

  assign hdr_second = hldf_pkg::DIGIT_BASE + {{(hldf_pkg::BYTE_W-hldf_pkg::SLOT_W){1'b0}}, slot_id};
  assign hdr_match  = (hunt_window[0] == hldf_pkg::HDR_FIRST) && (hunt_window[1] == hdr_second)
                      && (rx_byte == hldf_pkg::HDR_THIRD);

  always_comb begin
    hunt_window_next      = hunt_window;
    byte_count_next       = byte_count;
    length_value_next     = length_value;
    length_high_byte_next = length_high_byte;
    command_hold_next     = command_hold;
    header_locked_next    = header_locked;
    past_length           = 1'b0;
    last                  = 1'b0;

    if (!header_locked) begin
      if (byte_count < hldf_pkg::POS_WINDOW_FULL) begin
        hunt_window_next[byte_count[0]] = rx_byte;
        byte_count_next = byte_count + 17'd1;
      end else if (hdr_match) begin
        header_locked_next    = 1'b1;
        byte_count_next       = hldf_pkg::POS_COMMAND;
        length_value_next     = '0;
        length_high_byte_next = '0;
        command_hold_next     = '0;
      end else begin
        // slide the window by one byte
        hunt_window_next[0] = hunt_window[1];
        hunt_window_next[1] = rx_byte;
        byte_count_next     = hldf_pkg::POS_WINDOW_FULL;
      end
    end else begin
      if (byte_count == hldf_pkg::POS_COMMAND) begin
        command_hold_next = rx_byte;
      end else if (byte_count == hldf_pkg::POS_LEN_HIGH) begin
        length_high_byte_next = rx_byte;
      end else if (byte_count == hldf_pkg::POS_LEN_LOW) begin
        length_value_next = {length_high_byte, rx_byte};
      end
      past_length = (byte_count >= hldf_pkg::POS_LEN_LOW);
      last = past_length &&
             (byte_count == ({1'b0, length_value_next} + hldf_pkg::POS_LEN_LOW));
      if (last) begin
        header_locked_next  = 1'b0;
        byte_count_next     = '0;
        hunt_window_next[0] = '0;
        hunt_window_next[1] = '0;
      end else begin
        byte_count_next = byte_count + 17'd1;
      end
    end
  end

  assign res_valid          = accept && header_locked;
  assign res.data_byte      = rx_byte;
  assign res.frame_position = byte_count;
  assign res.command_code   = command_hold_next;
  assign res.payload_length = past_length ? length_value_next : '0;
  assign res.last_of_frame  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_window[0]   <= '0;
      hunt_window[1]   <= '0;
      byte_count       <= '0;
      length_value     <= '0;
      length_high_byte <= '0;
      command_hold     <= '0;
      header_locked    <= 1'b0;
    end else if (accept) begin
      hunt_window      <= hunt_window_next;
      byte_count       <= byte_count_next;
      length_value     <= length_value_next;
      length_high_byte <= length_high_byte_next;
      command_hold     <= command_hold_next;
      header_locked    <= header_locked_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/hldf_out_buf.sv
// result register with one skid entry so input takes one more result under stall
// depends on hldf_pkg
`timescale 1ns / 1ps
`default_nettype none

module hldf_out_buf (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire hldf_pkg::hldf_result_t   push_res,
  output logic                          can_accept,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output hldf_pkg::hldf_result_t        out_res,
  output hldf_pkg::hldf_buf_status_t    status
);

  logic                   skid_valid;
  hldf_pkg::hldf_result_t skid_res;
  logic                   out_take;

  assign out_take          = out_valid && out_ready;
  assign can_accept        = !skid_valid;
  assign status.out_valid  = out_valid;
  assign status.skid_valid = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (push) begin
        out_res <= push_res;
      end
    end else if (push) begin
      skid_res <= push_res;
    end
  end

endmodule

`default_nettype wire

// File: sim/tb_header_length_frame_deframer.sv
// self-checking testbench for header_length_frame_deframer: byte stream in, frame bytes out
// depends on hldf_pkg and the deframer rtl under hdl; a behavioural copy of the parser predicts
`timescale 1ns / 1ps

module tb_header_length_frame_deframer;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int STALL_CYCLES   = 300;

  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [hldf_pkg::BYTE_W-1:0]    s_tdata  = '0;   // [7:0] rx_byte
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  // [7:0] data_byte, [24:8] frame_position, [32:25] command_code,
  // [48:33] payload_length, [55:49] zero
  logic [hldf_pkg::TDATA_W-1:0]   m_tdata;
  logic                           m_tlast;   // last_of_frame
  logic                           psel     = 1'b0;
  logic                           penable  = 1'b0;
  logic                           pwrite   = 1'b0;
  logic [hldf_pkg::PADDR_W-1:0]   paddr    = '0;
  logic [hldf_pkg::PDATA_W-1:0]   pwdata   = '0;
  logic [hldf_pkg::PDATA_W-1:0]   prdata;
  logic                           pready;

  header_length_frame_deframer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser copy: hunt window, position, frame fields
  logic [hldf_pkg::BYTE_W-1:0] win_old   = '0;
  logic [hldf_pkg::BYTE_W-1:0] win_new   = '0;
  logic [hldf_pkg::POS_W-1:0]  byte_pos  = '0;
  logic [hldf_pkg::LEN_W-1:0]  len_full  = '0;
  logic [hldf_pkg::BYTE_W-1:0] len_high  = '0;
  logic [hldf_pkg::BYTE_W-1:0] cmd_held  = '0;
  logic                        in_frame  = 1'b0;
  logic [hldf_pkg::SLOT_W-1:0] slot_cur  = '0;

  hldf_pkg::hldf_result_t pending_bytes[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors        = 0;
  int bytes_sent    = 0;
  int results_seen  = 0;
  int frames_closed = 0;
  int slot_writes   = 0;
  int quiet_cycles  = 0;

  // receiver stall request: the test toggles stall_req, the receiver counts it down
  logic stall_req      = 1'b0;
  logic stall_req_seen = 1'b0;
  int   stall_left     = 0;

  function automatic logic [hldf_pkg::BYTE_W-1:0] slot_digit();
    return hldf_pkg::DIGIT_BASE + {4'h0, slot_cur};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic deframe_byte(input logic [hldf_pkg::BYTE_W-1:0] b);
    hldf_pkg::hldf_result_t r;
    logic [hldf_pkg::POS_W-1:0] pos;
    if (!in_frame) begin
      if (byte_pos < hldf_pkg::POS_WINDOW_FULL) begin
        if (byte_pos == '0) win_old = b;
        else win_new = b;
        byte_pos = byte_pos + 1'b1;
      end else if (win_old == hldf_pkg::HDR_FIRST && win_new == slot_digit() &&
                   b == hldf_pkg::HDR_THIRD) begin
        in_frame = 1'b1;
        byte_pos = hldf_pkg::POS_COMMAND;
        len_full = '0;
        len_high = '0;
        cmd_held = '0;
      end else begin
        win_old  = win_new;
        win_new  = b;
        byte_pos = hldf_pkg::POS_WINDOW_FULL;
      end
    end else begin
      pos = byte_pos;
      if (pos == hldf_pkg::POS_COMMAND) cmd_held = b;
      else if (pos == hldf_pkg::POS_LEN_HIGH) len_high = b;
      else if (pos == hldf_pkg::POS_LEN_LOW) len_full = {len_high, b};
      r.data_byte      = b;
      r.frame_position = pos;
      r.command_code   = cmd_held;
      r.payload_length = (pos >= hldf_pkg::POS_LEN_LOW) ? len_full : '0;
      r.last_of_frame  = (pos >= hldf_pkg::POS_LEN_LOW) &&
                         (pos == {1'b0, len_full} + hldf_pkg::POS_LEN_LOW);
      pending_bytes.push_back(r);
      if (r.last_of_frame) begin
        in_frame = 1'b0;
        byte_pos = '0;
        win_old  = '0;
        win_new  = '0;
      end else begin
        byte_pos = pos + 1'b1;
      end
    end
  endtask

  task automatic send_byte(input logic [hldf_pkg::BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [hldf_pkg::BYTE_W-1:0] cmd,
                            input logic [hldf_pkg::LEN_W-1:0] len);
    send_byte(hldf_pkg::HDR_FIRST);
    send_byte(slot_digit());
    send_byte(hldf_pkg::HDR_THIRD);
    send_byte(cmd);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    for (int i = 0; i < int'(len); i++) send_byte(hldf_pkg::BYTE_W'($urandom()));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    // hunted bytes give no result, so leave room for one still in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_slot(input logic [hldf_pkg::SLOT_W-1:0] s);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= hldf_pkg::ADDR_SLOT_ID;
    pwdata  <= ($urandom() & 32'hFFFF_FFF0) | {28'h0, s};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    slot_cur = s;
    slot_writes++;
    // read back straight after, setup phase follows the write access
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[hldf_pkg::SLOT_W-1:0] !== s)
      report_mismatch("slot_id read back", 64'(prdata), 64'(s));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_req != stall_req_seen) begin
      stall_req_seen <= stall_req;
      stall_left     <= STALL_CYCLES - 1;
      m_tready       <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    hldf_pkg::hldf_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tlast) frames_closed++;
      if (pending_bytes.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(m_tdata), 64'd0);
      end else begin
        want = pending_bytes.pop_front();
        if (m_tdata[7:0] !== want.data_byte)
          report_mismatch("data_byte", 64'(m_tdata[7:0]), 64'(want.data_byte));
        if (m_tdata[24:8] !== want.frame_position)
          report_mismatch("frame_position", 64'(m_tdata[24:8]),
                          64'(want.frame_position));
        if (m_tdata[32:25] !== want.command_code)
          report_mismatch("command_code", 64'(m_tdata[32:25]), 64'(want.command_code));
        if (m_tdata[48:33] !== want.payload_length)
          report_mismatch("payload_length", 64'(m_tdata[48:33]),
                          64'(want.payload_length));
        if (m_tdata[55:49] !== '0)
          report_mismatch("tdata padding", 64'(m_tdata[55:49]), 64'd0);
        if (m_tlast !== want.last_of_frame)
          report_mismatch("last_of_frame", 64'(m_tlast), 64'(want.last_of_frame));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               quiet_cycles, pending_bytes.size());
      $display("** header_length_frame_deframer: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset slot is zero; overlapping header start, wrong digit, slot fifteen
  task automatic test_directed_frames();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_frame(8'h00, 16'h0000);
    send_byte(hldf_pkg::HDR_FIRST);
    send_frame(8'hFF, 16'h0001);
    send_byte(hldf_pkg::HDR_FIRST);
    send_byte(hldf_pkg::DIGIT_BASE + 8'd1);
    send_byte(hldf_pkg::HDR_THIRD);
    wait_drained();
    write_slot(4'hF);
    // the old digit must no longer lock
    send_byte(hldf_pkg::HDR_FIRST);
    send_byte(hldf_pkg::DIGIT_BASE);
    send_byte(hldf_pkg::HDR_THIRD);
    send_frame(8'h5A, 16'h0000);
    wait_drained();
  endtask

  task automatic test_slot_change_mid_frame();
    write_slot(4'd9);
    send_byte(hldf_pkg::HDR_FIRST);
    send_byte(slot_digit());
    send_byte(hldf_pkg::HDR_THIRD);
    send_byte(8'hA5);
    send_byte(8'h00);
    wait_drained();
    write_slot(4'd3);
    // frame carries on under the old header; payload mimics it
    send_byte(8'h02);
    send_byte(hldf_pkg::HDR_FIRST);
    send_byte(hldf_pkg::DIGIT_BASE + 8'd9);
    send_frame(8'h3C, 16'h0003);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int spct, input int rpct, input int count,
                                     input logic [hldf_pkg::SLOT_W-1:0] slot);
    int start;
    int pick;
    logic [hldf_pkg::BYTE_W-1:0] b;
    write_slot(slot);
    send_idle_pct = spct;
    recv_idle_pct = rpct;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(hldf_pkg::BYTE_W'($urandom()),
                   hldf_pkg::LEN_W'(pick < 63 ? $urandom_range(0, 12)
                                              : $urandom_range(13, 60)));
      end else if (pick < 85) begin
        send_byte(hldf_pkg::HDR_FIRST);
        if ($urandom_range(0, 1)) begin
          send_byte(slot_digit() ^ hldf_pkg::BYTE_W'(1 << $urandom_range(0, 7)));
          send_byte(hldf_pkg::HDR_THIRD);
        end else begin
          send_byte(slot_digit());
          b = hldf_pkg::BYTE_W'($urandom());
          if (b == hldf_pkg::HDR_THIRD) b = ~b;
          send_byte(b);
        end
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(hldf_pkg::BYTE_W'($urandom()));
      end
    end
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering, then sender waits for all output
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_req = ~stall_req;
    send_frame(8'h77, 16'd24);
    wait_drained();
    send_frame(8'h78, 16'd4);
    wait_drained();
  endtask

  // length with a non-zero high byte
  task automatic test_long_frame();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_frame(8'hC3, 16'h0103);
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    test_slot_change_mid_frame();
    test_random_traffic(28, 55, 150, hldf_pkg::SLOT_W'($urandom_range(0, 15)));
    test_output_stall();
    test_random_traffic(55, 28, 150, hldf_pkg::SLOT_W'($urandom_range(0, 15)));
    test_random_traffic(0, 0, 150, 4'h0);
    test_long_frame();
    wait_drained();
    if (pending_bytes.size() != 0)
      report_mismatch("results left pending", 64'(pending_bytes.size()), 64'd0);
    $display("covered %0d bytes in, %0d results checked, %0d frames closed",
             bytes_sent, results_seen, frames_closed);
    $display("%0d slot settings, three idling mixes, output stall and a long frame",
             slot_writes);
    if (errors == 0) begin
      $display("** header_length_frame_deframer: PASSED **");
    end else begin
      $display("** header_length_frame_deframer: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/hldf_pkg.sv
hdl/hldf_parser.sv
hdl/hldf_out_buf.sv
hdl/header_length_frame_deframer.sv
sim/tb_header_length_frame_deframer.sv
